// ===== hw/rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and command codes for the bitmap shape rasterizer.
// ----------------------------------------------------------------------------
package bsr_pkg;

   // bitmap size; coordinate ports are 6 and 5 bits wide
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 32;

   typedef enum logic [2:0] {
      OP_CLEAR_ALL = 3'd0,
      OP_CLEAR_REG = 3'd1,
      OP_LINE      = 3'd2,
      OP_RECT      = 3'd3,
      OP_CIRCLE    = 3'd4,
      OP_READ      = 3'd5
   } opcode_type;

   localparam logic CSR_FIELD_WIDTH  = 1'b0;
   localparam logic CSR_FIELD_HEIGHT = 1'b1;

   localparam logic [6:0] FIELD_WIDTH_RESET  = 7'd35;
   localparam logic [5:0] FIELD_HEIGHT_RESET = 6'd25;

endpackage

// ===== hw/rtl/bsr_ram.sv =====
// ----------------------------------------------------------------------------
// bsr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hw/rtl/bitmap_shape_rasterizer.sv =====
// ----------------------------------------------------------------------------
// bitmap_shape_rasterizer
// One-bit bitmap with clear, region clear, line, rectangle, circle and read.
// ----------------------------------------------------------------------------
// One request at a time. The bitmap lives in a RAM that writes one cell per
// cycle, so the time a request takes is set by the cells it sweeps. A clear
// or region clear walks its N cells; a circle, its (2r)*(2r) bounding square;
// a line, one setup step, then per cell a bit-serial divide and a write; a
// rectangle, one line per row, each row with its own setup step; a read
// passes ST_READ and ST_READ2; a rejected or empty command goes straight to
// ST_DONE. After reset a clearing pass over the whole RAM runs before the
// first request is taken. The result waits in an output register, and the
// next request is taken the cycle after the result is accepted.
module bitmap_shape_rasterizer
   import bsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [5:0] req_first_x,
   input  logic [4:0] req_first_y,
   input  logic [5:0] req_second_x,
   input  logic [4:0] req_second_y,
   input  logic [5:0] req_circle_radius,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_status,
   output logic       rsp_cell_value,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

   typedef enum logic [3:0] {
      ST_WIPE, ST_IDLE, ST_SWEEP, ST_LSET, ST_LDIV, ST_LPUT, ST_READ, ST_READ2,
      ST_DONE
   } state_type;

   // sweep kinds share one x/y walker
   typedef enum logic [1:0] {SW_CLEAR, SW_CIRCLE} sweep_type;

   state_type   state_ff;
   sweep_type   sweep_ff;
   logic [6:0]  fw_ff;
   logic [5:0]  fh_ff;
   logic [6:0]  w_eff;
   logic [5:0]  h_eff;

   // sweep walker (wide enough for coordinates and bounds)
   logic [6:0]  x_ff, y_ff, xlo_ff, xhi_ff, yhi_ff;
   logic [6:0]  cx_ff, cy_ff;
   logic [11:0] rr_ff;

   // line engine
   logic [6:0]  lx0_ff, ly0_ff, lx1_ff, ly1_ff;
   logic [6:0]  a_ff, a1_ff, d_ff, b0_ff, k_ff;
   logic        steep_ff, bneg_ff;
   logic [6:0]  db_ff;
   logic        rect_ff;
   logic [6:0]  rrow_ff, rrowend_ff;
   logic [14:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [3:0]  dcnt_ff;

   logic        busy_rsp_ff;
   logic        st_ff;
   logic        val_ff;

   logic          ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic          ram_wd, ram_rd;

   bsr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   // effective field size
   always_comb begin
      w_eff = (fw_ff > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : fw_ff;
      h_eff = ({1'b0, fh_ff} > 7'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : fh_ff;
   end

   function automatic logic [AW-1:0] addr_of(input logic [6:0] x, input logic [6:0] y);
      addr_of = {y[YW-1:0], x[XW-1:0]};
   endfunction

   // request decode
   logic       acc;
   logic [6:0] ix0, iy0, ix1, iy1, ir;
   logic       all_in, circ_ok;
   always_comb begin
      ix0 = 7'(req_first_x);
      iy0 = 7'(req_first_y);
      ix1 = 7'(req_second_x);
      iy1 = 7'(req_second_y);
      ir  = 7'(req_circle_radius);
      all_in = ix0 < w_eff && ix1 < w_eff && iy0 < 7'(h_eff) && iy1 < 7'(h_eff);
      circ_ok = ix0 < w_eff && iy0 < 7'(h_eff) && ix0 >= ir && iy0 >= ir
                && (ix0 + ir) <= w_eff && (iy0 + ir) <= 7'(h_eff);
   end
   assign req_stall = (state_ff != ST_IDLE) || busy_rsp_ff;
   assign acc       = req_valid && !req_stall;

   // circle test for current sweep cell, on absolute offsets
   logic [6:0]  ddx, ddy;
   logic [12:0] dist_sq;
   always_comb begin
      ddx     = (cx_ff >= x_ff) ? cx_ff - x_ff : x_ff - cx_ff;
      ddy     = (cy_ff >= y_ff) ? cy_ff - y_ff : y_ff - cy_ff;
      dist_sq = 13'({6'd0, ddx} * {6'd0, ddx}) + 13'({6'd0, ddy} * {6'd0, ddy});
   end

   // line minor coordinate: quotient of the divider
   logic [6:0] minor;
   assign minor = 7'(quo_ff);

   // RAM ports
   always_comb begin
      ram_we = 1'b0;
      ram_wa = addr_of(x_ff, y_ff);
      ram_wd = 1'b0;
      ram_ra = addr_of(cx_ff, cy_ff);
      unique case (state_ff)
         ST_WIPE:  ram_we = 1'b1;
         ST_SWEEP: begin
            if (sweep_ff == SW_CLEAR) begin
               ram_we = 1'b1;
            end else begin
               ram_we = {6'd0, dist_sq} < {7'd0, rr_ff} ? 1'b1 : 1'b0;
               ram_wd = 1'b1;
            end
         end
         ST_LPUT: begin
            ram_we = 1'b1;
            ram_wd = 1'b1;
            ram_wa = steep_ff ? addr_of(minor, a_ff) : addr_of(a_ff, minor);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WIPE;
         fw_ff       <= FIELD_WIDTH_RESET;
         fh_ff       <= FIELD_HEIGHT_RESET;
         busy_rsp_ff <= 1'b0;
         x_ff        <= '0;
         y_ff        <= '0;
      end else begin
         // configuration
         if (csr_write) begin
            if (csr_index == CSR_FIELD_WIDTH) fw_ff <= csr_data;
            else                              fh_ff <= csr_data[5:0];
         end
         if (busy_rsp_ff && !rsp_stall) busy_rsp_ff <= 1'b0;

         unique case (state_ff)
            // reset clearing pass over the whole RAM
            ST_WIPE: begin
               if (x_ff == 7'(MAX_WIDTH - 1)) begin
                  x_ff <= '0;
                  if (y_ff == 7'(MAX_HEIGHT - 1)) state_ff <= ST_IDLE;
                  else y_ff <= y_ff + 7'd1;
               end else begin
                  x_ff <= x_ff + 7'd1;
               end
            end
            ST_IDLE: begin
               if (acc) begin
                  st_ff    <= 1'b0;
                  val_ff   <= 1'b0;
                  cx_ff    <= ix0;
                  cy_ff    <= iy0;
                  rect_ff  <= 1'b0;
                  state_ff <= ST_DONE;
                  case (req_opcode)
                     OP_CLEAR_ALL: begin
                        sweep_ff <= SW_CLEAR;
                        xlo_ff <= '0; x_ff <= '0; y_ff <= '0;
                        xhi_ff <= w_eff - 7'd1; yhi_ff <= 7'(h_eff) - 7'd1;
                        if (w_eff != 0 && h_eff != 0) state_ff <= ST_SWEEP;
                     end
                     OP_CLEAR_REG: begin
                        if (!all_in) st_ff <= 1'b1;
                        else begin
                           sweep_ff <= SW_CLEAR;
                           xlo_ff <= (ix0 < ix1) ? ix0 : ix1;
                           x_ff   <= (ix0 < ix1) ? ix0 : ix1;
                           xhi_ff <= (ix0 < ix1) ? ix1 : ix0;
                           y_ff   <= (iy0 < iy1) ? iy0 : iy1;
                           yhi_ff <= (iy0 < iy1) ? iy1 : iy0;
                           state_ff <= ST_SWEEP;
                        end
                     end
                     OP_LINE: begin
                        if (!all_in) st_ff <= 1'b1;
                        else begin
                           lx0_ff <= ix0; ly0_ff <= iy0;
                           lx1_ff <= ix1; ly1_ff <= iy1;
                           state_ff <= ST_LSET;
                        end
                     end
                     OP_RECT: begin
                        if (!all_in) st_ff <= 1'b1;
                        else begin
                           rect_ff <= 1'b1;
                           if (iy1 < iy0) begin
                              lx0_ff <= ix1; lx1_ff <= ix0;
                              rrow_ff <= iy1; rrowend_ff <= iy0;
                              ly0_ff <= iy1; ly1_ff <= iy1;
                           end else begin
                              lx0_ff <= ix0; lx1_ff <= ix1;
                              rrow_ff <= iy0; rrowend_ff <= iy1;
                              ly0_ff <= iy0; ly1_ff <= iy0;
                           end
                           if (iy0 != iy1) state_ff <= ST_LSET;
                        end
                     end
                     OP_CIRCLE: begin
                        if (!circ_ok) st_ff <= 1'b1;
                        else if (ir != 0) begin
                           sweep_ff <= SW_CIRCLE;
                           rr_ff  <= 12'({5'd0, ir} * {5'd0, ir});
                           xlo_ff <= ix0 - ir; x_ff <= ix0 - ir;
                           xhi_ff <= ix0 + ir - 7'd1;
                           y_ff   <= iy0 - ir; yhi_ff <= iy0 + ir - 7'd1;
                           state_ff <= ST_SWEEP;
                        end
                     end
                     OP_READ: begin
                        if (ix0 < w_eff && iy0 < 7'(h_eff)) state_ff <= ST_READ;
                        else st_ff <= 1'b1;
                     end
                     default: st_ff <= 1'b1;
                  endcase
               end
            end
            // rectangular walk, one cell per cycle
            ST_SWEEP: begin
               if (x_ff == xhi_ff) begin
                  x_ff <= xlo_ff;
                  if (y_ff == yhi_ff) state_ff <= ST_DONE;
                  else y_ff <= y_ff + 7'd1;
               end else begin
                  x_ff <= x_ff + 7'd1;
               end
            end
            // line setup: axis choice and endpoint order
            ST_LSET: begin : lset
               logic [6:0] dx, dy, a0, a1, b0, b1;
               logic       stp;
               dx  = (lx0_ff > lx1_ff) ? lx0_ff - lx1_ff : lx1_ff - lx0_ff;
               dy  = (ly0_ff > ly1_ff) ? ly0_ff - ly1_ff : ly1_ff - ly0_ff;
               stp = dx < dy;
               a0 = stp ? ly0_ff : lx0_ff; b0 = stp ? lx0_ff : ly0_ff;
               a1 = stp ? ly1_ff : lx1_ff; b1 = stp ? lx1_ff : ly1_ff;
               if (a0 > a1) begin
                  a_ff <= a1; a1_ff <= a0; b0_ff <= b1; d_ff <= a0 - a1;
                  bneg_ff <= b0 < b1; db_ff <= (b0 < b1) ? b1 - b0 : b0 - b1;
               end else begin
                  a_ff <= a0; a1_ff <= a1; b0_ff <= b0; d_ff <= a1 - a0;
                  bneg_ff <= b1 < b0; db_ff <= (b1 < b0) ? b0 - b1 : b1 - b0;
               end
               steep_ff <= stp;
               k_ff     <= '0;
               // degenerate line: the divider still yields b0 via d forced to 1
               state_ff <= ST_LDIV;
               dcnt_ff  <= 4'd0;
            end
            // restoring divide: (2*(b0*d +- db*k) + d) / (2d), one bit a cycle
            ST_LDIV: begin : ldiv
               logic [14:0] n, dd, rm;
               logic [14:0] qv;
               if (dcnt_ff == 4'd0) begin
                  dd = (d_ff == 0) ? 15'd2 : {7'd0, d_ff, 1'b0};
                  n  = (d_ff == 0) ? {7'd0, b0_ff, 1'b0} + 15'd1
                       : 15'(2 * (bneg_ff ? (b0_ff * d_ff - db_ff * k_ff)
                                          : (b0_ff * d_ff + db_ff * k_ff)))
                         + 15'(d_ff);
                  num_ff  <= n;
                  den_ff  <= dd;
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  dcnt_ff <= 4'd1;
               end else begin
                  rm = {rem_ff[13:0], num_ff[14]};
                  qv = {quo_ff[13:0], 1'b0};
                  if (rm >= den_ff) begin
                     rm = rm - den_ff;
                     qv[0] = 1'b1;
                  end
                  rem_ff <= rm;
                  quo_ff <= qv;
                  num_ff <= {num_ff[13:0], 1'b0};
                  if (dcnt_ff == 4'd15) state_ff <= ST_LPUT;
                  else dcnt_ff <= dcnt_ff + 4'd1;
               end
            end
            // write one line cell, advance major axis or next rectangle row
            ST_LPUT: begin
               if (a_ff == a1_ff) begin
                  if (rect_ff && (rrow_ff + 7'd1) != rrowend_ff) begin
                     rrow_ff <= rrow_ff + 7'd1;
                     ly0_ff  <= rrow_ff + 7'd1;
                     ly1_ff  <= rrow_ff + 7'd1;
                     state_ff <= ST_LSET;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end else begin
                  a_ff <= a_ff + 7'd1;
                  k_ff <= k_ff + 7'd1;
                  dcnt_ff <= 4'd0;
                  state_ff <= ST_LDIV;
               end
            end
            ST_READ:  state_ff <= ST_READ2;
            ST_READ2: begin
               val_ff   <= ram_rd;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               busy_rsp_ff <= 1'b1;
               state_ff    <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = busy_rsp_ff;
   assign rsp_status     = st_ff;
   assign rsp_cell_value = val_ff;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bitmap shape rasterizer against a behavioral bitmap model: each
// request's status and cell value are predicted and compared in order, under
// several field sizes and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import bsr_pkg::*;

   localparam int MW = 64;
   localparam int MH = 32;
   localparam int CYCLE_LIMIT = 10000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_opcode = '0;
   logic [5:0] req_first_x = '0;
   logic [4:0] req_first_y = '0;
   logic [5:0] req_second_x = '0;
   logic [4:0] req_second_y = '0;
   logic [5:0] req_circle_radius = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_status;
   logic       rsp_cell_value;
   logic       csr_write = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_data = '0;

   typedef struct packed {
      logic status;
      logic cell_value;
   } result_type;

   bitmap_shape_rasterizer dut (.*);

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow bitmap and field size
   logic       shadow_map [MH][MW];
   int         cols_in_use;
   int         rows_in_use;
   result_type pending_results[$];
   int         error_count;
   int         send_gap_pct;
   int         stall_pct;
   longint     cycle_count;

   function automatic int eff_cols();
      return cols_in_use > MW ? MW : cols_in_use;
   endfunction

   function automatic int eff_rows();
      return rows_in_use > MH ? MH : rows_in_use;
   endfunction

   function automatic void mark_cell(int x, int y, logic v);
      if (x >= 0 && x < MW && y >= 0 && y < MH) shadow_map[y][x] = v;
   endfunction

   // parametric line, minor axis rounded half away from zero
   function automatic void trace_line(int x0, int y0, int x1, int y1);
      int dx, dy, a0, a1, b0, b1, t, d, num, b;
      bit steep;
      dx = x0 > x1 ? x0 - x1 : x1 - x0;
      dy = y0 > y1 ? y0 - y1 : y1 - y0;
      steep = dx < dy;
      a0 = steep ? y0 : x0;
      b0 = steep ? x0 : y0;
      a1 = steep ? y1 : x1;
      b1 = steep ? x1 : y1;
      if (a0 > a1) begin
         t = a0; a0 = a1; a1 = t;
         t = b0; b0 = b1; b1 = t;
      end
      d = a1 - a0;
      if (d == 0) begin
         mark_cell(x0, y0, 1'b1);
         return;
      end
      for (int m = a0; m <= a1; m++) begin
         num = b0 * d + (b1 - b0) * (m - a0);
         b = (2 * num + d) / (2 * d);
         if (steep) mark_cell(b, m, 1'b1);
         else mark_cell(m, b, 1'b1);
      end
   endfunction

   // predicted result of one request; updates the shadow bitmap
   function automatic result_type rasterize(logic [2:0] op, int x0, int y0, int x1, int y1,
                                            int r);
      result_type res;
      int w, h, t;
      bit all_in;
      w = eff_cols();
      h = eff_rows();
      all_in = x0 < w && x1 < w && y0 < h && y1 < h;
      res = '0;
      case (op)
         OP_CLEAR_ALL: begin
            for (int y = 0; y < h; y++)
               for (int x = 0; x < w; x++) mark_cell(x, y, 1'b0);
         end
         OP_CLEAR_REG: begin
            if (!all_in) res.status = 1'b1;
            else begin
               if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
               if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
               for (int y = y0; y <= y1; y++)
                  for (int x = x0; x <= x1; x++) mark_cell(x, y, 1'b0);
            end
         end
         OP_LINE: begin
            if (!all_in) res.status = 1'b1;
            else trace_line(x0, y0, x1, y1);
         end
         OP_RECT: begin
            if (!all_in) res.status = 1'b1;
            else begin
               if (y1 < y0) begin
                  t = y0; y0 = y1; y1 = t;
                  t = x0; x0 = x1; x1 = t;
               end
               for (int y = y0; y < y1; y++) trace_line(x0, y, x1, y);
            end
         end
         OP_CIRCLE: begin
            if (!(x0 < w && y0 < h && x0 >= r && y0 >= r && x0 + r <= w && y0 + r <= h))
               res.status = 1'b1;
            else
               for (int x = x0 - r; x < x0 + r; x++)
                  for (int y = y0 - r; y < y0 + r; y++)
                     if ((x0 - x) * (x0 - x) + (y0 - y) * (y0 - y) < r * r)
                        mark_cell(x, y, 1'b1);
         end
         OP_READ: begin
            if (x0 < w && y0 < h) res.cell_value = shadow_map[y0][x0];
            else res.status = 1'b1;
         end
         default: res.status = 1'b1;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic got, logic want);
      error_count++;
      $display("MISMATCH %s: got %0b expected %0b at %0t", what, got, want, $realtime);
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_valid, 1'b0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_cell_value !== want.cell_value)
               report_mismatch("cell_value", rsp_cell_value, want.cell_value);
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // send one request and predict its result at acceptance
   task automatic send_request(logic [2:0] op, logic [5:0] x0, logic [4:0] y0,
                               logic [5:0] x1, logic [4:0] y1, logic [5:0] r);
      do @(negedge clock); while ($urandom_range(99) < send_gap_pct);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_first_x <= x0;
      req_first_y <= y0;
      req_second_x <= x1;
      req_second_y <= y1;
      req_circle_radius <= r;
      do @(posedge clock); while (req_stall);
      pending_results = {pending_results, rasterize(op, x0, y0, x1, y1, r)};
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_field(logic idx, logic [6:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FIELD_WIDTH) cols_in_use = value;
      else cols_in_use = cols_in_use;
      if (idx == CSR_FIELD_HEIGHT) rows_in_use = value[5:0];
   endtask

   task automatic set_field(int w, int h);
      wait_idle();
      write_field(CSR_FIELD_WIDTH, 7'(w));
      write_field(CSR_FIELD_HEIGHT, 7'(h));
   endtask

   task automatic read_back(int n);
      repeat (n)
         send_request(OP_READ, 6'($urandom_range(eff_cols())), 5'($urandom_range(eff_rows())),
                      '0, '0, '0);
   endtask

   // directed: extremes, every opcode, special cases
   task automatic test_directed();
      send_gap_pct = 0;
      stall_pct = 0;
      send_request(OP_READ, 6'd0, 5'd0, '0, '0, '0);
      send_request(OP_LINE, 6'd0, 5'd0, 6'd34, 5'd24, '0);
      send_request(OP_LINE, 6'd3, 5'd20, 6'd5, 5'd1, '0);       // steep
      send_request(OP_LINE, 6'd7, 5'd7, 6'd7, 5'd7, '0);        // single cell
      send_request(OP_READ, 6'd7, 5'd7, '0, '0, '0);
      send_request(OP_LINE, 6'd35, 5'd0, 6'd1, 5'd1, '0);       // out of range
      send_request(OP_RECT, 6'd30, 5'd10, 6'd2, 5'd4, '0);      // swapped corners
      send_request(OP_RECT, 6'd1, 5'd3, 6'd9, 5'd3, '0);        // equal rows
      send_request(OP_READ, 6'd30, 5'd4, '0, '0, '0);
      send_request(OP_CIRCLE, 6'd12, 5'd12, '0, '0, 6'd12);
      send_request(OP_CIRCLE, 6'd5, 5'd5, '0, '0, 6'd0);        // zero radius
      send_request(OP_CIRCLE, 6'd2, 5'd5, '0, '0, 6'd3);        // beyond edge
      send_request(OP_CLEAR_REG, 6'd20, 5'd3, 6'd4, 5'd15, '0); // mixed order
      send_request(OP_READ, 6'd10, 5'd10, '0, '0, '0);
      send_request(OP_READ, 6'd63, 5'd31, '0, '0, '0);
      send_request(3'd6, 6'd63, 5'd31, 6'd63, 5'd31, 6'd63);
      send_request(3'd7, '0, '0, '0, '0, '0);
      send_request(OP_CLEAR_ALL, '0, '0, '0, '0, '0);
      set_field(127, 63);                                       // above maximum
      send_request(OP_LINE, 6'd63, 5'd31, 6'd0, 5'd0, '0);
      send_request(OP_CIRCLE, 6'd32, 5'd16, '0, '0, 6'd16);
      send_request(OP_CIRCLE, 6'd32, 5'd31, '0, '0, 6'd32);
      send_request(OP_READ, 6'd63, 5'd31, '0, '0, '0);
      set_field(0, 0);                                          // zero size
      send_request(OP_CLEAR_ALL, '0, '0, '0, '0, '0);
      send_request(OP_READ, '0, '0, '0, '0, '0);
   endtask

   // random draws under one field size and idling pattern
   task automatic test_random(int w, int h, int gap, int stall, int n);
      int cw, ch, op, x0, y0, r;
      set_field(w, h);
      send_gap_pct = gap;
      stall_pct = stall;
      cw = eff_cols();
      ch = eff_rows();
      for (int i = 0; i < n; i++) begin
         op = $urandom_range(99);
         x0 = $urandom_range(cw - 1);
         y0 = $urandom_range(ch - 1);
         if (op < 4) send_request(OP_CLEAR_ALL, '0, '0, '0, '0, '0);
         else if (op < 8) send_request(3'($urandom_range(7)), 6'($urandom), 5'($urandom),
                                       6'($urandom), 5'($urandom), 6'($urandom));
         else if (op < 20) send_request(OP_CLEAR_REG, 6'(x0), 5'(y0),
                                        6'($urandom_range(cw - 1)),
                                        5'($urandom_range(ch - 1)), 6'($urandom));
         else if (op < 38) send_request(OP_LINE, 6'(x0), 5'(y0), 6'($urandom_range(cw - 1)),
                                        5'($urandom_range(ch - 1)), 6'($urandom));
         else if (op < 50) send_request(OP_RECT, 6'(x0), 5'(y0), 6'($urandom_range(cw - 1)),
                                        5'($urandom_range(ch - 1)), 6'($urandom));
         else if (op < 62) begin
            r = $urandom_range(8);
            send_request(OP_CIRCLE, 6'(x0), 5'(y0), 6'($urandom), 5'($urandom), 6'(r));
         end else if (op < 66)
            send_request(OP_READ, 6'($urandom), 5'($urandom), '0, '0, '0);
         else
            send_request(OP_READ, 6'(x0), 5'(y0), 6'($urandom), 5'($urandom), 6'($urandom));
      end
      read_back(4);
   endtask

   initial begin
      for (int y = 0; y < MH; y++)
         for (int x = 0; x < MW; x++) shadow_map[y][x] = 1'b0;
      cols_in_use = FIELD_WIDTH_RESET;
      rows_in_use = FIELD_HEIGHT_RESET;
      error_count = 0;
      cycle_count = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_field(35, 25);
      test_directed();
      test_random(35, 25, 0, 0, 70);
      test_random(64, 32, 65, 0, 70);
      test_random(1, 1, 0, 65, 30);
      test_random(20, 12, 0, 65, 70);
      test_random(100, 40, 25, 25, 60);
      test_random(64, 2, 0, 0, 50);
      test_random(3, 32, 25, 25, 40);
      wait_idle();
      repeat (200) @(negedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== bitmap_shape_rasterizer.f =====
hw/rtl/bsr_pkg.sv
hw/rtl/bsr_ram.sv
hw/rtl/bitmap_shape_rasterizer.sv
bench/testbench.sv
